// ===== design/flt_pkg.sv =====
// Shared types, constants and codes of the failed-login throttle table.
package flt_pkg;

    localparam int ENTRIES_DEF = 16;

    // Slot indexes and fill counts are sized for the largest table (256 slots).
    localparam int IDX_W  = 8;
    localparam int USED_W = 9;

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 64;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = 8;
    localparam int THR_W    = 16;
    localparam int MAXE_W   = 5;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 16;

    localparam logic [CNT_W-1:0]  MBA_RST  = 8'd5;
    localparam logic [THR_W-1:0]  THR_RST  = 16'd3;
    localparam logic [MAXE_W-1:0] MAXE_RST = 5'd16;
    localparam logic [CNT_W-1:0]  CNT_SAT  = 8'd255;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_QUERY = 2'd0,
        FUNC_FAIL  = 2'd1,
        FUNC_GOOD  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_BAD  = 2'd0,
        REG_THROTTLE = 2'd1,
        REG_MAX_ENT  = 2'd2,
        REG_UNUSED   = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SCAN1,
        ST_DECIDE,
        ST_SCAN2,
        ST_EVICT,
        ST_DONE
    } t_state;

    // Running summary handed from cell to cell along the chain.
    typedef struct packed {
        logic              match;
        logic [IDX_W-1:0]  match_idx;
        logic [CNT_W-1:0]  match_cnt;
        logic              free;
        logic [IDX_W-1:0]  free_idx;
        logic              old;
        logic [IDX_W-1:0]  old_idx;
        logic [TIME_W-1:0] old_age;
        logic [USED_W-1:0] used;
    } t_tok;

    // Broadcast command from the sequencer to every cell.
    typedef struct packed {
        logic             sweep;
        logic             clr;
        logic [IDX_W-1:0] clr_idx;
        logic             wr;
        logic             wr_new;
        logic [IDX_W-1:0] wr_idx;
        logic [CNT_W-1:0] wr_cnt;
    } t_cmd;

endpackage

// ===== design/flt_cell.sv =====
// One table slot: stored entry, local sweep and one step of the chained search.
module flt_cell #(
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  flt_pkg::t_cmd               i_cmd,
    input  logic [flt_pkg::KEY_W-1:0]   i_key_hi,
    input  logic [flt_pkg::KEY_W-1:0]   i_key_lo,
    input  logic [flt_pkg::TIME_W-1:0]  i_now,
    input  logic [flt_pkg::THR_W-1:0]   i_thr,
    input  flt_pkg::t_tok               i_tok,
    output flt_pkg::t_tok               o_tok
);

    localparam logic [flt_pkg::IDX_W-1:0] MY_IDX = flt_pkg::IDX_W'(IDX);

    logic                         r_valid;
    logic [flt_pkg::KEY_W-1:0]    r_key_hi;
    logic [flt_pkg::KEY_W-1:0]    r_key_lo;
    logic [flt_pkg::CNT_W-1:0]    r_cnt;
    logic [flt_pkg::TIME_W-1:0]   r_time;
    flt_pkg::t_tok                r_tok;
    flt_pkg::t_tok                n_tok;
    logic [flt_pkg::TIME_W-1:0]   age;
    logic                         expired;
    logic                         key_hit;

    assign age     = i_now - r_time;
    assign expired = age >= {{(flt_pkg::TIME_W-flt_pkg::THR_W){1'b0}}, i_thr};
    assign key_hit = (r_key_hi == i_key_hi) && (r_key_lo == i_key_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.wr && i_cmd.wr_idx == MY_IDX) begin
            r_valid <= 1'b1;
        end else if (i_cmd.clr && i_cmd.clr_idx == MY_IDX) begin
            r_valid <= 1'b0;
        end else if (i_cmd.sweep && expired) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && i_cmd.wr_idx == MY_IDX) begin
            if (i_cmd.wr_new) begin
                r_key_hi <= i_key_hi;
                r_key_lo <= i_key_lo;
            end
            r_cnt  <= i_cmd.wr_cnt;
            r_time <= i_now;
        end
    end

    // Ages only grow along the chain on a strict win, so ties keep the lower slot.
    always_comb begin
        n_tok = i_tok;
        if (r_valid && key_hit && !i_tok.match) begin
            n_tok.match     = 1'b1;
            n_tok.match_idx = MY_IDX;
            n_tok.match_cnt = r_cnt;
        end
        if (!r_valid && !i_tok.free) begin
            n_tok.free     = 1'b1;
            n_tok.free_idx = MY_IDX;
        end
        if (r_valid && (!i_tok.old || age > i_tok.old_age)) begin
            n_tok.old     = 1'b1;
            n_tok.old_idx = MY_IDX;
            n_tok.old_age = age;
        end
        n_tok.used = i_tok.used + flt_pkg::USED_W'(r_valid);
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_tok = r_tok;

endmodule

// ===== design/flt_ctrl.sv =====
// Sequencer: request capture, configuration registers, decisions and result register.
module flt_ctrl #(
    parameter int ENTRIES = flt_pkg::ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [flt_pkg::IN_DATA_W-1:0]   i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [flt_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input  logic                            i_cfg_wr_en,
    input  logic [flt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [flt_pkg::CFG_W-1:0]       i_cfg_wr_data,
    input  flt_pkg::t_tok                   i_tok,
    output flt_pkg::t_cmd                   o_cmd,
    output logic [flt_pkg::KEY_W-1:0]       o_key_hi,
    output logic [flt_pkg::KEY_W-1:0]       o_key_lo,
    output logic [flt_pkg::TIME_W-1:0]      o_now,
    output logic [flt_pkg::THR_W-1:0]       o_thr
);

    localparam int SCW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [SCW-1:0] SCAN_LAST = SCW'(ENTRIES - 1);

    flt_pkg::t_state                r_state, n_state;
    logic [SCW-1:0]                 r_scan_cnt;
    flt_pkg::t_func                 r_func;
    logic [flt_pkg::KEY_W-1:0]      r_key_hi;
    logic [flt_pkg::KEY_W-1:0]      r_key_lo;
    logic [flt_pkg::TIME_W-1:0]     r_now;
    logic [flt_pkg::CNT_W-1:0]      r_mba;
    logic [flt_pkg::THR_W-1:0]      r_thr;
    logic [flt_pkg::MAXE_W-1:0]     r_maxe;
    logic                           r_res_thr, n_res_thr;
    logic [flt_pkg::CNT_W-1:0]      r_res_cnt, n_res_cnt;
    logic                           r_res_ev, n_res_ev;
    logic [flt_pkg::IDX_W-1:0]      r_slot, n_slot;
    logic                           r_m_valid;
    logic [flt_pkg::OUT_DATA_W-1:0] r_m_data;
    logic                           accept;
    logic                           load;
    logic [flt_pkg::CNT_W-1:0]      inc_cnt;
    logic [flt_pkg::USED_W-1:0]     used_after;
    logic                           over_limit;
    flt_pkg::t_cmd                  cmd;

    assign accept = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == flt_pkg::ST_IDLE);
    assign load = (r_state == flt_pkg::ST_DONE) && (!r_m_valid || i_m_tready);

    assign inc_cnt = (i_tok.match_cnt == flt_pkg::CNT_SAT) ? flt_pkg::CNT_SAT
                                                            : i_tok.match_cnt + 8'd1;
    assign used_after = i_tok.used + flt_pkg::USED_W'(!i_tok.match && i_tok.free);
    // Slots in use never exceed ENTRIES, so comparing with max_entries alone
    // is the same as comparing with the smaller of the two.
    assign over_limit = used_after >
                        {{(flt_pkg::USED_W-flt_pkg::MAXE_W){1'b0}}, r_maxe};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mba  <= flt_pkg::MBA_RST;
            r_thr  <= flt_pkg::THR_RST;
            r_maxe <= flt_pkg::MAXE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (flt_pkg::t_reg_idx'(i_cfg_idx))
                flt_pkg::REG_MAX_BAD:  r_mba  <= i_cfg_wr_data[flt_pkg::CNT_W-1:0];
                flt_pkg::REG_THROTTLE: r_thr  <= i_cfg_wr_data;
                flt_pkg::REG_MAX_ENT:  r_maxe <= i_cfg_wr_data[flt_pkg::MAXE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= flt_pkg::t_func'(i_s_tdata[1:0]);
            r_key_hi <= i_s_tdata[65:2];
            r_key_lo <= i_s_tdata[129:66];
            r_now    <= i_s_tdata[161:130];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= flt_pkg::ST_IDLE;
            r_scan_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == flt_pkg::ST_SCAN1 || r_state == flt_pkg::ST_SCAN2) begin
                r_scan_cnt <= r_scan_cnt + SCW'(1);
            end else begin
                r_scan_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_thr <= n_res_thr;
        r_res_cnt <= n_res_cnt;
        r_res_ev  <= n_res_ev;
        r_slot    <= n_slot;
    end

    always_comb begin
        n_state   = r_state;
        n_res_thr = r_res_thr;
        n_res_cnt = r_res_cnt;
        n_res_ev  = r_res_ev;
        n_slot    = r_slot;
        cmd       = '0;
        unique case (r_state)
            flt_pkg::ST_IDLE: begin
                n_res_thr = 1'b0;
                n_res_cnt = '0;
                n_res_ev  = 1'b0;
                if (accept) begin
                    n_state = flt_pkg::ST_SWEEP;
                end
            end
            flt_pkg::ST_SWEEP: begin
                cmd.sweep = (r_func == flt_pkg::FUNC_QUERY) ||
                            (r_func == flt_pkg::FUNC_FAIL);
                n_state = flt_pkg::ST_SCAN1;
            end
            flt_pkg::ST_SCAN1: begin
                if (r_scan_cnt == SCAN_LAST) begin
                    n_state = flt_pkg::ST_DECIDE;
                end
            end
            flt_pkg::ST_DECIDE: begin
                n_state = flt_pkg::ST_DONE;
                unique case (r_func)
                    flt_pkg::FUNC_QUERY: begin
                        if (i_tok.match) begin
                            n_res_cnt = i_tok.match_cnt;
                            n_res_thr = i_tok.match_cnt >= r_mba;
                        end
                    end
                    flt_pkg::FUNC_FAIL: begin
                        cmd.wr     = 1'b1;
                        cmd.wr_new = !i_tok.match;
                        cmd.wr_cnt = i_tok.match ? inc_cnt : 8'd1;
                        if (i_tok.match) begin
                            cmd.wr_idx = i_tok.match_idx;
                        end else if (i_tok.free) begin
                            cmd.wr_idx = i_tok.free_idx;
                        end else begin
                            // Full table: the oldest entry gives up its slot.
                            cmd.wr_idx = i_tok.old_idx;
                            n_res_ev   = 1'b1;
                        end
                        n_slot    = cmd.wr_idx;
                        n_res_cnt = cmd.wr_cnt;
                        if ((i_tok.match || i_tok.free) && over_limit) begin
                            n_state = flt_pkg::ST_SCAN2;
                        end
                    end
                    flt_pkg::FUNC_GOOD: begin
                        cmd.clr     = i_tok.match;
                        cmd.clr_idx = i_tok.match_idx;
                    end
                    default: ;
                endcase
            end
            flt_pkg::ST_SCAN2: begin
                if (r_scan_cnt == SCAN_LAST) begin
                    n_state = flt_pkg::ST_EVICT;
                end
            end
            flt_pkg::ST_EVICT: begin
                cmd.clr     = i_tok.old;
                cmd.clr_idx = i_tok.old_idx;
                n_res_ev    = 1'b1;
                if (i_tok.old_idx == r_slot) begin
                    n_res_cnt = '0;
                end
                n_state = flt_pkg::ST_DONE;
            end
            flt_pkg::ST_DONE: begin
                if (load) begin
                    n_state = flt_pkg::ST_IDLE;
                end
            end
            default: n_state = flt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_m_data <= {6'd0, r_res_ev, r_res_cnt, r_res_thr};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_cmd      = cmd;
    assign o_key_hi   = r_key_hi;
    assign o_key_lo   = r_key_lo;
    assign o_now      = r_now;
    assign o_thr      = r_thr;

    // An eviction after the write only starts when something is in use.
    a_evict_has_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == flt_pkg::ST_EVICT |-> i_tok.old)
        else $error("eviction without an entry in use");

    // A full table always offers an oldest entry to replace.
    a_full_has_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == flt_pkg::ST_DECIDE && r_func == flt_pkg::FUNC_FAIL &&
         !i_tok.match && !i_tok.free) |-> i_tok.old)
        else $error("full table without an oldest entry");

    // Only a query may report throttled, and only a failed attempt may evict.
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_res_thr || r_func == flt_pkg::FUNC_QUERY) &&
                 (!r_res_ev || r_func == flt_pkg::FUNC_FAIL))
        else $error("result flag set for the wrong operation");

    // A new request is not taken until the previous one has reached the result register.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready)
        else $error("request accepted while another is in progress");

endmodule

// ===== design/failed_login_throttle_table_top.sv =====
// Top level of the failed-login throttle table: sequencer and chain of slot cells.
//
// Requests arrive on the slave stream: tdata carries func, address_high,
// address_low and time_now. Each request gives exactly one result on the
// master stream: throttled, attempt_count and evicted. Func 0 queries a
// client, 1 records a failed attempt, 2 a successful one; 3 does nothing.
// The three settings are written through the plain write port. The user must
// do so only while the block is idle; the block itself does not enforce it.
// The table is a row of ENTRIES cells. Every search (match, first free slot,
// oldest entry, fill count) is a summary passed from cell to cell and
// registered in each cell, so a pass runs the full length of the row. A
// failed attempt that pushes the table over its limit makes a second pass.
// The next request can be taken in the cycle after the result is loaded
// into the output register. One request is in progress at a time.
// After reset every slot is empty and the settings are 5 attempts, 3 seconds
// and 16 entries; no clearing pass is needed. The result sits in an output
// register; if the receiver stalls, the next request can be taken and worked
// on, and it waits at its end until the register is free.
module failed_login_throttle_table_top #(
    parameter int ENTRIES = flt_pkg::ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // func [1:0], address_high [65:2], address_low [129:66], time_now [161:130]
    input  logic [flt_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // throttled [0], attempt_count [8:1], evicted [9]
    output logic [flt_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input  logic                            i_cfg_wr_en,
    input  logic [flt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [flt_pkg::CFG_W-1:0]       i_cfg_wr_data
);

    flt_pkg::t_tok                 tok [ENTRIES];
    flt_pkg::t_cmd                 cmd;
    logic [flt_pkg::KEY_W-1:0]     key_hi;
    logic [flt_pkg::KEY_W-1:0]     key_lo;
    logic [flt_pkg::TIME_W-1:0]    now;
    logic [flt_pkg::THR_W-1:0]     thr;

    flt_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_axis_tvalid),
        .o_s_tready    (o_s_axis_tready),
        .i_s_tdata     (i_s_axis_tdata),
        .o_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (i_m_axis_tready),
        .o_m_tdata     (o_m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_tok         (tok[ENTRIES-1]),
        .o_cmd         (cmd),
        .o_key_hi      (key_hi),
        .o_key_lo      (key_lo),
        .o_now         (now),
        .o_thr         (thr)
    );

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        flt_pkg::t_tok tok_in;
        if (g == 0) begin : g_head
            assign tok_in = '0;
        end else begin : g_link
            assign tok_in = tok[g-1];
        end
        flt_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (cmd),
            .i_key_hi (key_hi),
            .i_key_lo (key_lo),
            .i_now    (now),
            .i_thr    (thr),
            .i_tok    (tok_in),
            .o_tok    (tok[g])
        );
    end

endmodule

// ===== bench/failed_login_throttle_table_top_tb.sv =====
// Self-checking stream testbench for the failed-login throttle table, with its own table predictor.
module failed_login_throttle_table_top_tb;
    import flt_pkg::*;

    localparam int NSLOTS       = ENTRIES_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 2 * NSLOTS + 10;
    localparam int POOL_SIZE    = 24;
    localparam int HOT_CLIENTS  = 6;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        logic             throttled;
        logic [CNT_W-1:0] attempt_count;
        logic             evicted;
    } t_verdict;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // func [1:0], address_high [65:2], address_low [129:66], time_now [161:130]
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // throttled [0], attempt_count [8:1], evicted [9]
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]      i_cfg_wr_data = '0;

    // Shadow copy of the table and its settings.
    logic              slot_used  [NSLOTS] = '{default: 1'b0};
    logic [KEY_W-1:0]  slot_hi    [NSLOTS];
    logic [KEY_W-1:0]  slot_lo    [NSLOTS];
    logic [CNT_W-1:0]  slot_count [NSLOTS];
    logic [TIME_W-1:0] slot_stamp [NSLOTS];
    logic [CNT_W-1:0]  lock_threshold = MBA_RST;
    logic [THR_W-1:0]  expiry_secs = THR_RST;
    logic [MAXE_W-1:0] capacity = MAXE_RST;

    t_verdict          expected_verdicts [$];
    logic [TIME_W-1:0] now_secs = '0;
    int                mismatch_count = 0;
    int                cycle_count = 0;
    int                stall_left = 0;
    bit                source_gaps_on = 1'b1;
    bit                sink_stalls_on = 1'b1;

    failed_login_throttle_table_top #(.ENTRIES(NSLOTS)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [TIME_W-1:0] age_of(input int s, input logic [TIME_W-1:0] now);
        return now - slot_stamp[s];
    endfunction

    function automatic void expire_stale(input logic [TIME_W-1:0] now);
        for (int s = 0; s < NSLOTS; s++) begin
            if (slot_used[s] && age_of(s, now) >= {16'b0, expiry_secs})
                slot_used[s] = 1'b0;
        end
    endfunction

    function automatic int find_client(input logic [KEY_W-1:0] hi, input logic [KEY_W-1:0] lo);
        for (int s = 0; s < NSLOTS; s++) begin
            if (slot_used[s] && slot_hi[s] == hi && slot_lo[s] == lo)
                return s;
        end
        return -1;
    endfunction

    function automatic int first_free();
        for (int s = 0; s < NSLOTS; s++) begin
            if (!slot_used[s])
                return s;
        end
        return -1;
    endfunction

    // Strictly greater age wins, so ties stay with the lowest slot.
    function automatic int oldest_slot(input logic [TIME_W-1:0] now);
        int best;
        logic [TIME_W-1:0] best_age;
        best = -1;
        best_age = '0;
        for (int s = 0; s < NSLOTS; s++) begin
            if (slot_used[s] && (best < 0 || age_of(s, now) > best_age)) begin
                best = s;
                best_age = age_of(s, now);
            end
        end
        return best;
    endfunction

    function automatic int used_total();
        int n;
        n = 0;
        for (int s = 0; s < NSLOTS; s++)
            if (slot_used[s])
                n++;
        return n;
    endfunction

    function automatic t_verdict throttle_table_step(input t_func op,
            input logic [KEY_W-1:0] hi, input logic [KEY_W-1:0] lo,
            input logic [TIME_W-1:0] now);
        t_verdict v;
        int s;
        int victim;
        int limit;
        v = '0;
        limit = (capacity < NSLOTS) ? int'(capacity) : NSLOTS;
        case (op)
            FUNC_QUERY: begin
                expire_stale(now);
                s = find_client(hi, lo);
                if (s >= 0) begin
                    v.attempt_count = slot_count[s];
                    v.throttled = (slot_count[s] >= lock_threshold);
                end
            end
            FUNC_FAIL: begin
                expire_stale(now);
                s = find_client(hi, lo);
                if (s < 0) begin
                    s = first_free();
                    if (s < 0) begin
                        // Full table: the oldest entry gives up its slot.
                        victim = oldest_slot(now);
                        s = (victim < 0) ? 0 : victim;
                        v.evicted = 1'b1;
                    end
                    slot_used[s] = 1'b1;
                    slot_hi[s] = hi;
                    slot_lo[s] = lo;
                    slot_count[s] = '0;
                end
                if (slot_count[s] != CNT_SAT)
                    slot_count[s] = slot_count[s] + 1'b1;
                slot_stamp[s] = now;
                if (!v.evicted && used_total() > limit) begin
                    victim = oldest_slot(now);
                    if (victim >= 0) begin
                        slot_used[victim] = 1'b0;
                        v.evicted = 1'b1;
                    end
                end
                if (slot_used[s])
                    v.attempt_count = slot_count[s];
            end
            FUNC_GOOD: begin
                s = find_client(hi, lo);
                if (s >= 0)
                    slot_used[s] = 1'b0;
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s, expected %0d, got %0d",
                     cycle_count, what, want, got);
        mismatch_count++;
    endtask

    task automatic send_request(input t_func op, input logic [KEY_W-1:0] hi,
            input logic [KEY_W-1:0] lo, input logic [TIME_W-1:0] now);
        int gap;
        if (source_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tdata  <= IN_DATA_W'({now, lo, hi, op});
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_verdicts.push_back(throttle_table_step(op, hi, lo, now));
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_setting(input t_reg_idx idx, input logic [CFG_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_idx     <= idx;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_MAX_BAD:  lock_threshold = value[CNT_W-1:0];
            REG_THROTTLE: expiry_secs = value[THR_W-1:0];
            REG_MAX_ENT:  capacity = value[MAXE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [CNT_W-1:0] threshold,
            input logic [THR_W-1:0] expiry, input logic [MAXE_W-1:0] cap);
        write_setting(REG_MAX_BAD, CFG_W'(threshold));
        write_setting(REG_THROTTLE, expiry);
        write_setting(REG_MAX_ENT, CFG_W'(cap));
    endtask

    // Settings as left by reset; covers each operation, address extremes and time wrap.
    task automatic test_basic_operations();
        logic [KEY_W-1:0] ones;
        ones = '1;
        send_request(FUNC_QUERY, '0, '0, 32'd0);
        repeat (5) send_request(FUNC_FAIL, '0, '0, 32'd0);
        send_request(FUNC_QUERY, '0, '0, 32'd1);
        send_request(FUNC_QUERY, '0, 64'd1, 32'd1);
        send_request(FUNC_QUERY, 64'h8000_0000_0000_0000, '0, 32'd1);
        send_request(FUNC_GOOD, '0, '0, 32'd2);
        send_request(FUNC_QUERY, '0, '0, 32'd2);
        send_request(FUNC_GOOD, '0, '0, 32'd2);
        send_request(FUNC_NONE, ones, ones, 32'd2);
        send_request(FUNC_FAIL, ones, ones, 32'd2);
        send_request(FUNC_QUERY, ones, ones, 32'd5);
        send_request(FUNC_FAIL, ones, ones, 32'd5);
        send_request(FUNC_FAIL, ones, ones, 32'd7);
        send_request(FUNC_FAIL, ones, ones, 32'hFFFF_FFFF);
        send_request(FUNC_QUERY, ones, ones, 32'd1);
        now_secs = 32'd1;
        drain_results();
    endtask

    // The count stops at its ceiling and crosses the highest threshold.
    task automatic test_count_saturation();
        logic [KEY_W-1:0] hi;
        logic [KEY_W-1:0] lo;
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
        apply_settings(8'd255, 16'hFFFF, 5'd16);
        now_secs = 32'd500;
        for (int n = 1; n <= 257; n++) begin
            send_request(FUNC_FAIL, hi, lo, now_secs);
            if (n == 254)
                send_request(FUNC_QUERY, hi, lo, now_secs);
        end
        send_request(FUNC_QUERY, hi, lo, now_secs);
        drain_results();
    endtask

    // Zero limits, a single-entry table and a full table taking a new client.
    task automatic test_table_limits();
        logic [KEY_W-1:0] key_hi [NSLOTS + 2];
        logic [KEY_W-1:0] key_lo [NSLOTS + 2];
        foreach (key_hi[k]) begin
            key_hi[k] = {$urandom, $urandom};
            key_lo[k] = {$urandom, $urandom};
        end
        now_secs = 32'd1000;
        // Everything expires, and a new entry that is itself the oldest is dropped.
        apply_settings(8'd5, 16'd0, 5'd0);
        write_setting(REG_UNUSED, 16'hFFFF);
        send_request(FUNC_FAIL, key_hi[0], key_lo[0], now_secs);
        send_request(FUNC_QUERY, key_hi[0], key_lo[0], now_secs);
        drain_results();

        apply_settings(8'd0, 16'd100, 5'd1);
        send_request(FUNC_FAIL, key_hi[1], key_lo[1], now_secs);
        send_request(FUNC_QUERY, key_hi[2], key_lo[2], now_secs);
        send_request(FUNC_QUERY, key_hi[1], key_lo[1], now_secs);
        send_request(FUNC_FAIL, key_hi[2], key_lo[2], now_secs);
        send_request(FUNC_QUERY, key_hi[1], key_lo[1], now_secs);
        send_request(FUNC_QUERY, key_hi[2], key_lo[2], now_secs);
        drain_results();

        // A limit above the slot count leaves only the full-table eviction.
        apply_settings(8'd5, 16'hFFFF, 5'd31);
        for (int k = 0; k < NSLOTS + 1; k++) begin
            now_secs = now_secs + 1;
            send_request(FUNC_FAIL, key_hi[k], key_lo[k], now_secs);
        end
        send_request(FUNC_FAIL, key_hi[NSLOTS + 1], key_lo[NSLOTS + 1], now_secs);
        send_request(FUNC_QUERY, key_hi[0], key_lo[0], now_secs);
        send_request(FUNC_QUERY, key_hi[NSLOTS], key_lo[NSLOTS], now_secs);
        drain_results();
    endtask

    // Mostly repeat clients from a small pool so that counts build up, entries age
    // out and the table overflows; fresh addresses now and then as noise.
    task automatic test_random_traffic(input logic [CNT_W-1:0] threshold,
            input logic [THR_W-1:0] expiry, input logic [MAXE_W-1:0] cap,
            input logic [TIME_W-1:0] start_secs, input int max_step,
            input int requests, input bit with_idling);
        logic [KEY_W-1:0] pool_hi [POOL_SIZE];
        logic [KEY_W-1:0] pool_lo [POOL_SIZE];
        logic [KEY_W-1:0] hi;
        logic [KEY_W-1:0] lo;
        t_func op;
        int pick;
        int roll;
        source_gaps_on = with_idling;
        sink_stalls_on = with_idling;
        apply_settings(threshold, expiry, cap);
        now_secs = start_secs;
        foreach (pool_hi[k]) begin
            pool_hi[k] = {$urandom, $urandom};
            pool_lo[k] = {$urandom, $urandom};
        end
        // Near neighbours of the first client differ in a single address bit.
        pool_hi[1] = pool_hi[0];
        pool_lo[1] = pool_lo[0] ^ (64'd1 << $urandom_range(0, 63));
        pool_hi[2] = pool_hi[0] ^ (64'd1 << $urandom_range(0, 63));
        pool_lo[2] = pool_lo[0];
        for (int n = 0; n < requests; n++) begin
            if ($urandom_range(0, 2) == 0)
                now_secs = now_secs + $urandom_range(0, max_step);
            roll = $urandom_range(0, 99);
            op = (roll < 45) ? FUNC_FAIL :
                 (roll < 78) ? FUNC_QUERY :
                 (roll < 96) ? FUNC_GOOD : FUNC_NONE;
            if ($urandom_range(0, 9) == 0) begin
                hi = {$urandom, $urandom};
                lo = {$urandom, $urandom};
            end else begin
                pick = ($urandom_range(0, 1) == 0) ? $urandom_range(0, HOT_CLIENTS - 1)
                                                   : $urandom_range(0, POOL_SIZE - 1);
                hi = pool_hi[pick];
                lo = pool_lo[pick];
            end
            send_request(op, hi, lo, now_secs);
        end
        drain_results();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_verdict want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("result with no request outstanding", 0,
                                int'(o_m_axis_tdata));
            end else begin
                want = expected_verdicts.pop_front();
                if (o_m_axis_tdata[0] !== want.throttled)
                    report_mismatch("throttled", int'(want.throttled),
                                    int'(o_m_axis_tdata[0]));
                if (o_m_axis_tdata[8:1] !== want.attempt_count)
                    report_mismatch("attempt_count", int'(want.attempt_count),
                                    int'(o_m_axis_tdata[8:1]));
                if (o_m_axis_tdata[9] !== want.evicted)
                    report_mismatch("evicted", int'(want.evicted),
                                    int'(o_m_axis_tdata[9]));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[failed_login_throttle_table_top] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_operations();
        test_count_saturation();
        test_table_limits();
        test_random_traffic(8'd3, 16'd10, 5'd16, now_secs + $urandom_range(1, 32'h7000_0000),
                            3, 260, 1'b1);
        test_random_traffic(8'd1, 16'hFFFF, 5'd4, 32'hFFFF_FF00, 3, 240, 1'b1);
        test_random_traffic(8'd2, 16'd1, 5'd31, now_secs + $urandom_range(1, 1000),
                            1, 240, 1'b1);
        test_random_traffic(8'd0, 16'd0, 5'd0, now_secs + $urandom_range(1, 1000),
                            2, 120, 1'b1);
        test_random_traffic(CNT_W'($urandom_range(1, 8)), THR_W'($urandom_range(2, 40)),
                            MAXE_W'($urandom_range(1, 16)),
                            now_secs + $urandom_range(1, 32'h0FFF_FFFF), 4, 240, 1'b1);
        test_random_traffic(8'd4, 16'd6, 5'd8, now_secs + $urandom_range(1, 1000),
                            2, 260, 1'b0);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[failed_login_throttle_table_top] OK");
        else
            $display("[failed_login_throttle_table_top] ERROR");
        $finish;
    end

endmodule
